// ----- hdl/psd_pkg.sv -----
`timescale 1ns / 1ps
package psd_pkg;

    // Width of the distance result, unsigned Q13.4.
    localparam int DIST_W = 17;

    // Default coordinate width, signed Q11.4.
    localparam int COORD_W_DEF = 16;

endpackage

// ----- hdl/psd_front.sv -----
`timescale 1ns / 1ps
module psd_front #(
    parameter int COORD_WIDTH = psd_pkg::COORD_W_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [COORD_WIDTH-1:0] i_query_x,
    input  logic signed [COORD_WIDTH-1:0] i_query_y,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    output logic                          o_valid,
    output logic [4*COORD_WIDTH+1:0]      o_num,
    output logic [2*COORD_WIDTH:0]        o_den
);
    import psd_pkg::*;

    localparam int DW  = COORD_WIDTH + 1;
    localparam int PW  = 2 * DW;
    localparam int SW  = PW + 1;
    localparam int SQ  = 2 * COORD_WIDTH + 1;
    localparam int CMW = 2 * COORD_WIDTH + 1;
    localparam int NW  = 2 * CMW;

    logic signed [DW-1:0] qx, qy, sx, sy, ex, ey;
    assign qx = {i_query_x[COORD_WIDTH-1], i_query_x};
    assign qy = {i_query_y[COORD_WIDTH-1], i_query_y};
    assign sx = {i_start_x[COORD_WIDTH-1], i_start_x};
    assign sy = {i_start_y[COORD_WIDTH-1], i_start_y};
    assign ex = {i_end_x[COORD_WIDTH-1], i_end_x};
    assign ey = {i_end_y[COORD_WIDTH-1], i_end_y};

    // Stage 1: segment vector, offset from the start and offset from the end.
    logic                 r_v1;
    logic signed [DW-1:0] r_dx, r_dy, r_wx, r_wy, r_vx, r_vy;

    // Stage 2: all products.
    logic                 r_v2;
    logic signed [PW-1:0] r_dxx, r_dyy, r_wxdx, r_wydy, r_wxdy, r_wydx;
    logic signed [PW-1:0] r_wxx, r_wyy, r_vxx, r_vyy;

    // Stage 3: sums.
    logic                 r_v3;
    logic [SQ-1:0]        r_len2, r_wd, r_vd;
    logic signed [SW-1:0] r_dot, r_cross;

    // Stage 4: case selection.
    logic                 r_v4;
    logic                 r_perp;
    logic [SQ-1:0]        r_pt;
    logic [CMW-1:0]       r_c;
    logic [SQ-1:0]        r_den4;

    // Stage 5: numerator of the square-root search.
    logic                 r_v5;
    logic [NW-1:0]        r_num;
    logic [SQ-1:0]        r_den5;

    logic [SW-1:0]        len2_s, wd_s, vd_s, dot_s, cross_s;
    logic                 n_endpt;
    logic signed [SW-1:0] cross_neg;

    always_comb begin
        len2_s  = {r_dxx[PW-1], r_dxx} + {r_dyy[PW-1], r_dyy};
        wd_s    = {r_wxx[PW-1], r_wxx} + {r_wyy[PW-1], r_wyy};
        vd_s    = {r_vxx[PW-1], r_vxx} + {r_vyy[PW-1], r_vyy};
        dot_s   = {r_wxdx[PW-1], r_wxdx} + {r_wydy[PW-1], r_wydy};
        cross_s = {r_wxdy[PW-1], r_wxdy} - {r_wydx[PW-1], r_wydx};
    end

    assign n_endpt   = (r_dot <= 0)
                    || (r_dot >= $signed({{(SW - SQ){1'b0}}, r_len2}));
    assign cross_neg = -r_cross;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx <= ex - sx;
            r_dy <= ey - sy;
            r_wx <= qx - sx;
            r_wy <= qy - sy;
            r_vx <= qx - ex;
            r_vy <= qy - ey;

            r_dxx  <= r_dx * r_dx;
            r_dyy  <= r_dy * r_dy;
            r_wxdx <= r_wx * r_dx;
            r_wydy <= r_wy * r_dy;
            r_wxdy <= r_wx * r_dy;
            r_wydx <= r_wy * r_dx;
            r_wxx  <= r_wx * r_wx;
            r_wyy  <= r_wy * r_wy;
            r_vxx  <= r_vx * r_vx;
            r_vyy  <= r_vy * r_vy;

            r_len2  <= len2_s[SQ-1:0];
            r_wd    <= wd_s[SQ-1:0];
            r_vd    <= vd_s[SQ-1:0];
            r_dot   <= $signed(dot_s);
            r_cross <= $signed(cross_s);

            // Endpoint cases search with a unit denominator; the nearer
            // endpoint gives the smaller floored root.
            if (r_len2 == '0) begin
                r_perp <= 1'b0;
                r_pt   <= r_wd;
                r_den4 <= SQ'(1);
            end else if (n_endpt) begin
                r_perp <= 1'b0;
                r_pt   <= (r_wd < r_vd) ? r_wd : r_vd;
                r_den4 <= SQ'(1);
            end else begin
                r_perp <= 1'b1;
                r_pt   <= r_wd;
                r_den4 <= r_len2;
            end
            r_c <= r_cross[SW-1] ? cross_neg[CMW-1:0] : r_cross[CMW-1:0];

            r_num  <= r_perp ? (NW'(r_c) * NW'(r_c)) : NW'(r_pt);
            r_den5 <= r_den4;
        end
    end

    assign o_valid = r_v5;
    assign o_num   = r_num;
    assign o_den   = r_den5;

endmodule

// ----- hdl/psd_cell.sv -----
`timescale 1ns / 1ps
module psd_cell #(
    parameter int BIT = 0,
    parameter int SQ  = 33,
    parameter int NW  = 66,
    parameter int QW  = 50,
    parameter int CPW = 70
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [NW-1:0]               i_num,
    input  logic [SQ-1:0]               i_den,
    input  logic [psd_pkg::DIST_W-1:0]  i_k,
    input  logic [CPW-1:0]              i_p,
    input  logic [QW-1:0]               i_q,
    output logic                        o_valid,
    output logic [NW-1:0]               o_num,
    output logic [SQ-1:0]               o_den,
    output logic [psd_pkg::DIST_W-1:0]  o_k,
    output logic [CPW-1:0]              o_p,
    output logic [QW-1:0]               o_q
);
    import psd_pkg::*;

    // The cell holds k, p = k*k*den and q = k*den, so trying one more bit
    // of k needs only shifts and adds: (k+2^b)^2*den = p + q*2^(b+1) + den*4^b.
    logic [CPW-1:0] trial;
    logic           take;

    assign trial = i_p + (CPW'(i_q) << (BIT + 1)) + (CPW'(i_den) << (2 * BIT));
    assign take  = trial <= CPW'(i_num);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_num <= i_num;
            o_den <= i_den;
            if (take) begin
                o_k <= i_k | (DIST_W'(1) << BIT);
                o_p <= trial;
                o_q <= i_q + (QW'(i_den) << BIT);
            end else begin
                o_k <= i_k;
                o_p <= i_p;
                o_q <= i_q;
            end
        end
    end

endmodule

// ----- hdl/point_segment_distance_core.sv -----
`timescale 1ns / 1ps
// Distance from a query point to a 2-D line segment, signed Q11.4 in,
// floored unsigned Q13.4 out.
// Input channel: i_valid with the six coordinates; a request is taken at a
// rising edge where i_valid is high and o_stall is low.
// Output channel: o_valid with o_distance; a result is taken at a rising
// edge where o_valid is high and i_stall is low.
// The pipeline has five front stages (differences, products, sums, case
// selection, squaring of the cross product) and one cell per result bit,
// seventeen in all, each settling one bit of the floored root.
// Throughput is one request per cycle unless the receiver stalls; the chain
// of cells sets this figure, each cell passing its partial root on when enabled.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_stall rises in the same cycle; it falls as soon as the result goes.
// Reset is synchronous and active low; it empties the pipeline, and no
// other state is kept, so the first request may follow straight after.
module point_segment_distance_core #(
    parameter int COORD_WIDTH = psd_pkg::COORD_W_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_query_x,
    input  logic signed [COORD_WIDTH-1:0] i_query_y,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [psd_pkg::DIST_W-1:0]    o_distance
);
    import psd_pkg::*;

    localparam int SQ   = 2 * COORD_WIDTH + 1;
    localparam int NW   = 2 * SQ;
    localparam int QW   = DIST_W + SQ;
    localparam int TW   = 2 * DIST_W + SQ + 1;
    localparam int CPW  = (NW > TW) ? NW : TW;

    // The pipeline moves whenever the final result register is free or
    // being emptied in this cycle.
    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    logic              w_valid [0:DIST_W];
    logic [NW-1:0]     w_num   [0:DIST_W];
    logic [SQ-1:0]     w_den   [0:DIST_W];
    logic [DIST_W-1:0] w_k     [0:DIST_W];
    logic [CPW-1:0]    w_p     [0:DIST_W];
    logic [QW-1:0]     w_q     [0:DIST_W];

    psd_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_valid),
        .i_query_x (i_query_x),
        .i_query_y (i_query_y),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .o_valid   (w_valid[0]),
        .o_num     (w_num[0]),
        .o_den     (w_den[0])
    );

    // The search starts from k = 0, so both running products are zero.
    assign w_k[0] = '0;
    assign w_p[0] = '0;
    assign w_q[0] = '0;

    // Cell i decides bit DIST_W-1-i, most significant first.
    for (genvar gi = 0; gi < DIST_W; gi++) begin : g_cell
        psd_cell #(
            .BIT (DIST_W - 1 - gi),
            .SQ  (SQ),
            .NW  (NW),
            .QW  (QW),
            .CPW (CPW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_valid[gi]),
            .i_num   (w_num[gi]),
            .i_den   (w_den[gi]),
            .i_k     (w_k[gi]),
            .i_p     (w_p[gi]),
            .i_q     (w_q[gi]),
            .o_valid (w_valid[gi+1]),
            .o_num   (w_num[gi+1]),
            .o_den   (w_den[gi+1]),
            .o_k     (w_k[gi+1]),
            .o_p     (w_p[gi+1]),
            .o_q     (w_q[gi+1])
        );
    end

    // The last cell's registers are the output register.
    assign o_valid    = w_valid[DIST_W];
    assign o_distance = w_k[DIST_W];

`ifndef SYNTH
    a_stall_only_with_result : assert property (@(posedge i_clk)
        disable iff (!i_rst_n) o_stall |-> o_valid)
        else $error("input stalled with no result waiting");

    a_result_held : assert property (@(posedge i_clk)
        disable iff (!i_rst_n) (o_valid && i_stall) |=>
        (o_valid && $stable(o_distance)))
        else $error("waiting result lost or changed");

    a_reset_empties : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present after reset");
`endif

endmodule

// ----- bench/psd_checker.sv -----
`timescale 1ns / 1ps
module psd_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_dut_stall,
    input  logic signed [15:0] i_query_x,
    input  logic signed [15:0] i_query_y,
    input  logic signed [15:0] i_start_x,
    input  logic signed [15:0] i_start_y,
    input  logic signed [15:0] i_end_x,
    input  logic signed [15:0] i_end_y,
    input  logic               i_out_valid,
    input  logic               i_rx_stall,
    input  logic [psd_pkg::DIST_W-1:0] i_distance,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_results
);

    logic [psd_pkg::DIST_W-1:0] expected_distances[$];

    // Largest k below 2^17 with k*k*den <= num.
    function automatic logic [16:0] floor_root_ratio(logic [127:0] num, logic [63:0] den);
        logic [16:0] k;
        logic [16:0] t;
        logic [127:0] prod;
        k = '0;
        for (int b = 16; b >= 0; b--) begin
            t = k | (17'd1 << b);
            prod = 128'(t) * 128'(t) * 128'(den);
            if (prod <= num) k = t;
        end
        return k;
    endfunction

    function automatic logic [16:0] endpoint_distance(longint ax, longint ay);
        return floor_root_ratio(128'(ax * ax + ay * ay), 64'd1);
    endfunction

    function automatic logic [16:0] segment_distance(longint qx, longint qy, longint sx,
                                                     longint sy, longint ex, longint ey);
        longint dx, dy, wx, wy, len2, dot, cr;
        logic [16:0] d0, d1;
        dx = ex - sx; dy = ey - sy;
        wx = qx - sx; wy = qy - sy;
        len2 = dx * dx + dy * dy;
        dot = wx * dx + wy * dy;
        if (len2 == 0) return endpoint_distance(wx, wy);
        if (dot <= 0 || dot >= len2) begin
            d0 = endpoint_distance(wx, wy);
            d1 = endpoint_distance(qx - ex, qy - ey);
            return (d0 < d1) ? d0 : d1;
        end
        cr = wx * dy - wy * dx;
        if (cr < 0) cr = -cr;
        return floor_root_ratio(128'(cr) * 128'(cr), 64'(len2));
    endfunction

    assign o_pending = expected_distances.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_results <= 0;
        end else begin
            if (i_valid && !i_dut_stall)
                expected_distances.push_back(segment_distance(i_query_x, i_query_y,
                    i_start_x, i_start_y, i_end_x, i_end_y));
            if (i_out_valid && !i_rx_stall) begin
                o_results <= o_results + 1;
                if (expected_distances.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d",
                             $time, i_distance);
                    o_fail_count <= o_fail_count + 1;
                end else if (expected_distances[0] !== i_distance) begin
                    $display("%0t: distance mismatch, expected %0d, actual %0d",
                             $time, expected_distances[0], i_distance);
                    o_fail_count <= o_fail_count + 1;
                    void'(expected_distances.pop_front());
                end else begin
                    void'(expected_distances.pop_front());
                end
            end
        end
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

    logic clk, rst_n, in_valid, dut_stall, out_valid, rx_stall;
    logic signed [15:0] qx, qy, sx, sy, ex, ey;
    logic [psd_pkg::DIST_W-1:0] distance;
    int fail_count, pending, results, cycles;
    int rx_idle;
    bit quiet;

    localparam int LIMIT = 200000;

    point_segment_distance_core u_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(dut_stall),
        .i_query_x(qx), .i_query_y(qy), .i_start_x(sx), .i_start_y(sy),
        .i_end_x(ex), .i_end_y(ey), .o_valid(out_valid), .i_stall(rx_stall),
        .o_distance(distance)
    );

    psd_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_dut_stall(dut_stall),
        .i_query_x(qx), .i_query_y(qy), .i_start_x(sx), .i_start_y(sy),
        .i_end_x(ex), .i_end_y(ey), .i_out_valid(out_valid), .i_rx_stall(rx_stall),
        .i_distance(distance), .o_fail_count(fail_count), .o_pending(pending),
        .o_results(results)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Random receiver stall in bursts, switched off near the end.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("point_segment_distance_core regression: fail");
            $finish;
        end
        if (!rst_n) begin
            rx_stall <= 1'b0;
            rx_idle <= 0;
        end else if (quiet) rx_stall <= 1'b0;
        else if (rx_idle > 0) begin
            rx_idle <= rx_idle - 1;
            rx_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            rx_idle <= $urandom_range(0, 3);
            rx_stall <= 1'b1;
        end else rx_stall <= 1'b0;
    end

    function automatic logic signed [15:0] coord(int mode);
        case (mode)
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'(int'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    // Present one request and hold it until it is taken; a random idle burst may precede it.
    task automatic send(input logic signed [15:0] a, b, c, d, e, f);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        qx <= a; qy <= b; sx <= c; sy <= d; ex <= e; ey <= f;
        @(posedge clk);
        while (dut_stall) @(posedge clk);
    endtask

    initial begin
        int m;
        logic signed [15:0] a, b, c, d;
        quiet = 0;
        rst_n = 0; in_valid = 0;
        qx = 0; qy = 0; sx = 0; sy = 0; ex = 0; ey = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Directed: extremes, zero-length segment, point on the line, both ends, inside.
        send(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
        send(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
        send(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
        send(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send(16'sd16, 16'sd16, 16'sd0, 16'sd0, 16'sd32, 16'sd32);
        send(-16'sd16, -16'sd16, 16'sd0, 16'sd0, 16'sd32, 16'sd32);
        send(16'sd48, 16'sd48, 16'sd0, 16'sd0, 16'sd32, 16'sd32);
        send(16'sd16, 16'sd40, 16'sd0, 16'sd0, 16'sd32, 16'sd0);
        send(16'sd16, 16'sd40, 16'sd32, 16'sd0, 16'sd0, 16'sd0);
        send(16'sd0, 16'sd40, 16'sd0, 16'sd0, 16'sd32, 16'sd0);
        send(16'sd32, 16'sd40, 16'sd0, 16'sd0, 16'sd32, 16'sd0);
        send(-16'sd1, -16'sd1, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
        send(16'sd5, 16'sd7, 16'sd3, 16'sd3, 16'sd3, 16'sd3);
        for (int i = 0; i < 520; i++) begin
            if (i > 440) quiet = 1;
            m = $urandom_range(0, 9);
            if (m < 2) begin
                a = coord(3); b = coord(3);
                send(coord(3), coord(3), a, b, a, b);
            end else if (m < 5) begin
                a = coord(2); b = coord(2); c = coord(2); d = coord(2);
                send(a + coord(2), b + coord(2), a, b, c, d);
            end else if (m == 5) begin
                send(coord($urandom_range(0, 3)), coord($urandom_range(0, 3)),
                     coord($urandom_range(0, 3)), coord($urandom_range(0, 3)),
                     coord($urandom_range(0, 3)), coord($urandom_range(0, 3)));
            end else begin
                send(coord(3), coord(3), coord(3), coord(3), coord(3), coord(3));
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        $display("Sent %0d requests covering extremes, degenerate segments and", 535);
        $display("projections inside and beyond the ends; %0d results checked.", results);
        if (fail_count == 0 && pending == 0)
            $display("point_segment_distance_core regression: pass");
        else
            $display("point_segment_distance_core regression: fail");
        $finish;
    end

endmodule
